// ----- hdl/rsb_pkg.sv -----
package rsb_pkg;

   // fixed field widths of the ports
   localparam int KIND_W  = 2;
   localparam int ARG_W   = 11;
   localparam int LAST_W  = 10;
   localparam int FOUND_W = 10;
   localparam int COUNT_W = 11;

   localparam int DEF_NUM_POSITIONS = 1024;
   localparam logic [LAST_W-1:0] LAST_RESET = 10'd1023;

   // item kinds, coded as on req_kind
   typedef enum logic [KIND_W-1:0] {
      OP_RESTORE = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_FIND    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // token control handed from cell to cell
   typedef struct packed {
      logic   valid;
      op_type op;
   } tok_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_CHECK,
      ST_WALK
   } state_type;

endpackage

// ----- hdl/rank_select_bitmap_unit.sv -----
// rank_select_bitmap_unit
//
//   channel | ports                                     | handshake
//   --------+-------------------------------------------+------------------------------
//   request | req_kind, req_argument                    | start && !busy
//   result  | rsp_found_position, rsp_rank_out_of_range,| rsp_valid, one cycle, no stall
//           | rsp_remaining_count                       |
//   config  | csr_last_position                         | csr_write_enable
//
// Find walks the cell chain one tree level per cycle. Remove adds one
// presence-bit read first. Restore sweeps every leaf of the padded tree.
// A bad rank, an outside position or kind 3 is answered straight from idle;
// removing an absent position is answered after the presence-bit read.
// Reset runs the same sweep, with busy high and no result.
// One item is in flight at a time; the result receiver cannot stall.
module rank_select_bitmap_unit #(
   parameter int NUM_POSITIONS = rsb_pkg::DEF_NUM_POSITIONS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [rsb_pkg::KIND_W-1:0]   req_kind,
   input  logic [rsb_pkg::ARG_W-1:0]    req_argument,
   output logic                         rsp_valid,
   output logic [rsb_pkg::FOUND_W-1:0]  rsp_found_position,
   output logic                         rsp_rank_out_of_range,
   output logic [rsb_pkg::COUNT_W-1:0]  rsp_remaining_count,
   input  logic                         csr_write_enable,
   input  logic [rsb_pkg::LAST_W-1:0]   csr_last_position
);
   import rsb_pkg::*;

   // tree padded to a power of two; padding leaves are never present
   localparam int LEVELS = $clog2(NUM_POSITIONS);
   localparam int CW     = LEVELS + 1;
   localparam int WW     = (CW > ARG_W) ? CW : ARG_W;
   localparam int LEAVES = 1 << LEVELS;
   localparam logic [WW-1:0] NUM_W  = WW'(NUM_POSITIONS);
   localparam logic [WW-1:0] LAST_P = WW'(NUM_POSITIONS - 1);

   state_type          state_ff, state_in;
   logic [LEVELS-1:0]  sw_ff, sw_in;
   logic               pend_ff, pend_in;
   logic [CW-1:0]      total_ff, total_in;
   logic [LEVELS-1:0]  pos_ff, pos_in;
   logic [LAST_W-1:0]  last_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FOUND_W-1:0] rsp_found_ff, rsp_found_in;
   logic               rsp_flag_ff, rsp_flag_in;

   logic               pres_mem [LEAVES];
   logic               pres_rd_ff;
   logic               pres_we;
   logic [LEVELS-1:0]  pres_wa;
   logic               pres_wd;

   logic [WW-1:0]      arg_w;
   logic [WW-1:0]      lim_w;
   logic [CW-1:0]      sweep_total;
   logic               sweep_en;

   tok_ctl_type        inj_ctl;
   logic [CW-1:0]      inj_key;
   logic [LEVELS-1:0]  inj_idx;

   tok_ctl_type        link_ctl [1:LEVELS];
   logic [LEVELS-1:0]  link_idx [1:LEVELS];
   logic [CW-1:0]      link_key [1:LEVELS];

   assign arg_w       = WW'(req_argument);
   assign lim_w       = (WW'(last_ff) >= LAST_P) ? LAST_P : WW'(last_ff);
   assign sweep_total = CW'(lim_w) + CW'(1);
   assign inj_idx     = '0;

   // ---------------- level chain ----------------
   for (genvar l = 1; l <= LEVELS; l++) begin : g_level
      tok_ctl_type       c_in_ctl;
      logic [LEVELS-1:0] c_in_idx;
      logic [CW-1:0]     c_in_key;

      if (l == 1) begin : g_head
         assign c_in_ctl = inj_ctl;
         assign c_in_idx = inj_idx;
         assign c_in_key = inj_key;
      end else begin : g_body
         assign c_in_ctl = link_ctl[l-1];
         assign c_in_idx = link_idx[l-1];
         assign c_in_key = link_key[l-1];
      end

      rsb_level_cell #(
         .LEVELS (LEVELS),
         .LEVEL  (l)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_ctl      (c_in_ctl),
         .in_idx      (c_in_idx),
         .in_key      (c_in_key),
         .out_ctl     (link_ctl[l]),
         .out_idx     (link_idx[l]),
         .out_key     (link_key[l]),
         .sweep_en    (sweep_en),
         .sweep_idx   (sw_ff),
         .sweep_total (sweep_total)
      );
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      sw_in        = sw_ff;
      pend_in      = pend_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = '0;
      rsp_flag_in  = 1'b0;
      inj_ctl      = '{valid: 1'b0, op: OP_NONE};
      inj_key      = '0;
      pres_we      = 1'b0;
      pres_wa      = sw_ff;
      pres_wd      = 1'b0;
      sweep_en     = 1'b0;

      unique case (state_ff)
         ST_SWEEP: begin
            sweep_en = 1'b1;
            pres_we  = 1'b1;
            pres_wd  = (WW'(sw_ff) <= lim_w);
            if (sw_ff == '1) begin
               state_in     = ST_IDLE;
               total_in     = sweep_total;
               rsp_valid_in = pend_ff;
               pend_in      = 1'b0;
            end else begin
               sw_in = sw_ff + LEVELS'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               unique case (op_type'(req_kind))
                  OP_RESTORE: begin
                     state_in = ST_SWEEP;
                     sw_in    = '0;
                     pend_in  = 1'b1;
                  end
                  OP_REMOVE: begin
                     if (arg_w >= NUM_W) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        pos_in   = LEVELS'(req_argument);
                        state_in = ST_CHECK;
                     end
                  end
                  OP_FIND: begin
                     if ((arg_w == '0) || (arg_w > WW'(total_ff))) begin
                        rsp_valid_in = 1'b1;
                        rsp_flag_in  = 1'b1;
                     end else begin
                        inj_ctl  = '{valid: 1'b1, op: OP_FIND};
                        inj_key  = CW'(req_argument);
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (pres_rd_ff) begin
               inj_ctl  = '{valid: 1'b1, op: OP_REMOVE};
               inj_key  = CW'(pos_ff);
               pres_we  = 1'b1;
               pres_wa  = pos_ff;
               total_in = total_ff - CW'(1);
               state_in = ST_WALK;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (link_ctl[LEVELS].valid) begin
               rsp_valid_in = 1'b1;
               if (link_ctl[LEVELS].op == OP_FIND) begin
                  rsp_found_in = FOUND_W'(link_idx[LEVELS]);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sw_ff        <= '0;
         pend_ff      <= 1'b0;
         total_ff     <= '0;
         last_ff      <= LAST_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         pend_ff      <= pend_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            last_ff <= csr_last_position;
         end
      end
      pos_ff       <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   // presence bits, read at accept so a remove can test its leaf
   always_ff @(posedge clock) begin
      pres_rd_ff <= pres_mem[LEVELS'(req_argument)];
      if (pres_we) begin
         pres_mem[pres_wa] <= pres_wd;
      end
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_found_position    = rsp_found_ff;
   assign rsp_rank_out_of_range = rsp_flag_ff;
   assign rsp_remaining_count   = COUNT_W'(total_ff);

`ifndef SYNTHESIS
   a_exit_in_walk: assert property (@(posedge clock) disable iff (reset)
      link_ctl[LEVELS].valid |-> (state_ff == ST_WALK))
      else $error("token leaves the chain outside a walk");

   a_find_lands: assert property (@(posedge clock) disable iff (reset)
      (link_ctl[LEVELS].valid && (link_ctl[LEVELS].op == OP_FIND))
         |-> (link_key[LEVELS] == CW'(1)))
      else $error("find reached a leaf with rank left over");

   a_flag_zero_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rank_out_of_range) |-> (rsp_found_position == '0))
      else $error("out-of-range result carries a position");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SWEEP) |-> (WW'(total_ff) <= NUM_W))
      else $error("remaining count above position total");
`endif

endmodule

// ----- hdl/rsb_level_cell.sv -----
// One tree level: subtree counts of every node on this level, one token slot.
module rsb_level_cell #(
   parameter int LEVELS = 10,
   parameter int LEVEL  = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rsb_pkg::tok_ctl_type     in_ctl,
   input  logic [LEVELS-1:0]        in_idx,
   input  logic [LEVELS:0]          in_key,
   output rsb_pkg::tok_ctl_type     out_ctl,
   output logic [LEVELS-1:0]        out_idx,
   output logic [LEVELS:0]          out_key,
   input  logic                     sweep_en,
   input  logic [LEVELS-1:0]        sweep_idx,
   input  logic [LEVELS:0]          sweep_total
);
   import rsb_pkg::*;

   localparam int CW    = LEVELS + 1;
   localparam int SPAN  = LEVELS - LEVEL;          // log2 of leaves under one node
   localparam int NW    = SPAN + 1;                // node count width
   localparam int DEPTH = 1 << LEVEL;
   localparam logic [LEVELS-1:0] LOW_MASK = LEVELS'((1 << SPAN) - 1);
   localparam logic [CW-1:0]     SPAN_CNT = CW'(1 << SPAN);

   logic [NW-1:0]     cnt_mem [DEPTH];
   logic [NW-1:0]     cnt_ff;
   tok_ctl_type       ctl_ff;
   logic [LEVELS-1:0] idx_ff;
   logic [CW-1:0]     key_ff;
   logic [LEVEL-1:0]  addr_ff;

   logic              rd_bit;
   logic [LEVEL-1:0]  rd_addr;
   logic              sweep_we;
   logic              dec_we;
   logic [CW-1:0]     sweep_diff;
   logic [CW-1:0]     sweep_cnt;
   logic              wr_en;
   logic [LEVEL-1:0]  wr_addr;
   logic [NW-1:0]     wr_data;
   logic [CW-1:0]     left_cnt;
   logic              go_right;
   logic              step_bit;

   // remove reads the node on its path, find reads the left child
   assign rd_bit  = (in_ctl.op == OP_REMOVE) ? in_key[SPAN] : 1'b0;
   assign rd_addr = LEVEL'({in_idx, rd_bit});

   // restore: node i*2^SPAN covers positions from sweep_idx up
   assign sweep_we   = sweep_en && ((sweep_idx & LOW_MASK) == '0);
   assign sweep_diff = sweep_total - CW'(sweep_idx);
   assign sweep_cnt  = (sweep_total <= CW'(sweep_idx)) ? '0 :
                       (sweep_diff > SPAN_CNT) ? SPAN_CNT : sweep_diff;

   assign dec_we  = ctl_ff.valid && (ctl_ff.op == OP_REMOVE);
   assign wr_en   = sweep_we || dec_we;
   assign wr_addr = sweep_en ? sweep_idx[LEVELS-1 -: LEVEL] : addr_ff;
   assign wr_data = sweep_en ? NW'(sweep_cnt) : (cnt_ff - NW'(1));

   assign left_cnt = CW'(cnt_ff);
   assign go_right = key_ff > left_cnt;
   assign step_bit = (ctl_ff.op == OP_FIND) ? go_right : addr_ff[0];

   assign out_ctl = ctl_ff;
   assign out_idx = LEVELS'({idx_ff, step_bit});
   assign out_key = ((ctl_ff.op == OP_FIND) && go_right) ? (key_ff - left_cnt) : key_ff;

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_mem[rd_addr];
      if (wr_en) begin
         cnt_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '{valid: 1'b0, op: OP_NONE};
      end else begin
         ctl_ff <= in_ctl;
      end
      idx_ff  <= in_idx;
      key_ff  <= in_key;
      addr_ff <= rd_addr;
   end

`ifndef SYNTHESIS
   a_dec_nonzero: assert property (@(posedge clock) disable iff (reset)
      dec_we |-> (cnt_ff != '0))
      else $error("remove decrements an empty node");

   a_sweep_alone: assert property (@(posedge clock) disable iff (reset)
      sweep_en |-> !ctl_ff.valid)
      else $error("restore sweep overlaps a token");

   a_rank_positive: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.valid && (ctl_ff.op == OP_FIND)) |-> (key_ff != '0))
      else $error("find token carries rank zero");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
   import rsb_pkg::*;

   // Tree size follows the block's default parameter.
   localparam int NPOS = DEF_NUM_POSITIONS;

   // Random items per setting of last_position, and the number of settings.
   localparam int PHASE_ITEMS = 160;
   localparam int PHASE_COUNT = 12;

   // The longest quiet stretch of a correct run is a restore sweep or the sweep
   // after reset, plus a sender gap. Allow several times that.
   localparam int WATCHDOG_LIMIT = 6000;

   // Cycles to keep watching for stray results after the last expected one.
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic [FOUND_W-1:0] found;
      logic               out_of_range;
      logic [COUNT_W-1:0] count;
   } answer_type;

   // One row of the directed plan. With set_span, last_position is written
   // (block idle) before the item goes in. With typed, the answer column is the
   // expected result; otherwise the bitmap predictor supplies it.
   typedef struct packed {
      logic              set_span;
      logic [LAST_W-1:0] span;
      op_type            kind;
      logic [ARG_W-1:0]  argument;
      logic              typed;
      answer_type        answer;
   } plan_row_type;

   localparam answer_type NO_ANSWER = '0;

   localparam int DIR_ROWS = 26;
   localparam plan_row_type DIR_PLAN [DIR_ROWS] = '{
      // after reset every position 0..1023 is present
      '{1'b0, 10'd0,    OP_FIND,    11'd1,    1'b1, '{10'd0,    1'b0, 11'd1024}},
      '{1'b0, 10'd0,    OP_FIND,    11'd1024, 1'b1, '{10'd1023, 1'b0, 11'd1024}},
      // rank zero, one past the count, all ones: flagged, nothing found
      '{1'b0, 10'd0,    OP_FIND,    11'd0,    1'b1, '{10'd0,    1'b1, 11'd1024}},
      '{1'b0, 10'd0,    OP_FIND,    11'd1025, 1'b1, '{10'd0,    1'b1, 11'd1024}},
      '{1'b0, 10'd0,    OP_FIND,    11'd2047, 1'b1, '{10'd0,    1'b1, 11'd1024}},
      // remove, then remove the same (now absent) position again
      '{1'b0, 10'd0,    OP_REMOVE,  11'd0,    1'b1, '{10'd0,    1'b0, 11'd1023}},
      '{1'b0, 10'd0,    OP_REMOVE,  11'd0,    1'b1, '{10'd0,    1'b0, 11'd1023}},
      // positions past the tree are ignored
      '{1'b0, 10'd0,    OP_REMOVE,  11'd2047, 1'b1, '{10'd0,    1'b0, 11'd1023}},
      '{1'b0, 10'd0,    OP_REMOVE,  11'd1024, 1'b1, '{10'd0,    1'b0, 11'd1023}},
      '{1'b0, 10'd0,    OP_REMOVE,  11'd1023, 1'b1, '{10'd0,    1'b0, 11'd1022}},
      '{1'b0, 10'd0,    OP_FIND,    11'd1,    1'b0, NO_ANSWER},
      '{1'b0, 10'd0,    OP_REMOVE,  11'd682,  1'b0, NO_ANSWER},
      '{1'b0, 10'd0,    OP_FIND,    11'd1022, 1'b1, '{10'd0,    1'b1, 11'd1021}},
      '{1'b0, 10'd0,    OP_FIND,    11'd1021, 1'b0, NO_ANSWER},
      // unused kind: no effect, no flag
      '{1'b0, 10'd0,    OP_NONE,    11'd2047, 1'b1, '{10'd0,    1'b0, 11'd1021}},
      '{1'b0, 10'd0,    OP_FIND,    11'd682,  1'b0, NO_ANSWER},
      // register write alone leaves the present set as it was
      '{1'b1, 10'd0,    OP_FIND,    11'd1,    1'b0, NO_ANSWER},
      '{1'b0, 10'd0,    OP_RESTORE, 11'd2047, 1'b1, '{10'd0,    1'b0, 11'd1}},
      '{1'b0, 10'd0,    OP_FIND,    11'd1,    1'b1, '{10'd0,    1'b0, 11'd1}},
      '{1'b0, 10'd0,    OP_REMOVE,  11'd5,    1'b1, '{10'd0,    1'b0, 11'd1}},
      // empty set: any find is out of range
      '{1'b0, 10'd0,    OP_REMOVE,  11'd0,    1'b1, '{10'd0,    1'b0, 11'd0}},
      '{1'b0, 10'd0,    OP_FIND,    11'd1,    1'b1, '{10'd0,    1'b1, 11'd0}},
      '{1'b0, 10'd0,    OP_RESTORE, 11'd0,    1'b1, '{10'd0,    1'b0, 11'd1}},
      '{1'b1, 10'd1023, OP_FIND,    11'd1,    1'b1, '{10'd0,    1'b0, 11'd1}},
      '{1'b0, 10'd0,    OP_RESTORE, 11'd0,    1'b1, '{10'd0,    1'b0, 11'd1024}},
      '{1'b0, 10'd0,    OP_FIND,    11'd1024, 1'b1, '{10'd1023, 1'b0, 11'd1024}}
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [KIND_W-1:0]   req_kind;
   logic [ARG_W-1:0]    req_argument;
   logic                rsp_valid;
   logic [FOUND_W-1:0]  rsp_found_position;
   logic                rsp_rank_out_of_range;
   logic [COUNT_W-1:0]  rsp_remaining_count;
   logic                csr_write_enable;
   logic [LAST_W-1:0]   csr_last_position;

   rank_select_bitmap_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_kind              (req_kind),
      .req_argument          (req_argument),
      .rsp_valid             (rsp_valid),
      .rsp_found_position    (rsp_found_position),
      .rsp_rank_out_of_range (rsp_rank_out_of_range),
      .rsp_remaining_count   (rsp_remaining_count),
      .csr_write_enable      (csr_write_enable),
      .csr_last_position     (csr_last_position)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Bitmap predictor: a flat presence map stands in for the count tree.
   // Selecting the rank-th set bit by a scan gives the same leaf that the
   // tree walk reaches whenever the rank is in range.
   // ---------------------------------------------------------------------
   bit [NPOS-1:0]     present_map;
   int unsigned       live_count;
   logic [LAST_W-1:0] span_last;     // register copy; used at the next restore and for remove noise

   answer_type  pending_answers [$];  // results owed by the block, oldest first
   int unsigned mismatches = 0;

   // sender pacing
   int unsigned burst_left = 0;
   bit          bursty = 1'b1;

   function automatic int unsigned nth_present(int unsigned rank);
      int unsigned seen;
      seen = 0;
      for (int p = 0; p < NPOS; p++) begin
         if (present_map[p]) begin
            seen++;
            if (seen == rank)
               return p;
         end
      end
      return 0;
   endfunction

   function automatic answer_type advance_bitmap(op_type k, logic [ARG_W-1:0] a);
      answer_type ans;
      ans = '0;
      case (k)
         OP_RESTORE: begin
            present_map = '0;
            for (int p = 0; p <= int'(span_last); p++)
               present_map[p] = 1'b1;
            live_count = int'(span_last) + 1;
         end
         OP_REMOVE: begin
            // absent or off-tree positions leave everything alone
            if (a < NPOS && present_map[a[LAST_W-1:0]]) begin
               present_map[a[LAST_W-1:0]] = 1'b0;
               live_count--;
            end
         end
         OP_FIND: begin
            if (a == 0 || a > live_count)
               ans.out_of_range = 1'b1;
            else
               ans.found = FOUND_W'(nth_present(a));
         end
         default: ;
      endcase
      ans.count = COUNT_W'(live_count);
      return ans;
   endfunction

   // ---------------------------------------------------------------------
   // Sender. Items go out in bursts; between bursts start drops for a random
   // number of cycles. Some phases run with no gaps at all.
   // ---------------------------------------------------------------------
   task automatic pace();
      if (burst_left == 0) begin
         if (bursty) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
   endtask

   // Holds start until the block takes the item, then books the expected
   // result. start is left high on return; the caller either drives the next
   // item in this same step or lowers it.
   task automatic issue_item(op_type k, logic [ARG_W-1:0] a, bit typed,
                             answer_type typed_answer);
      answer_type predicted;
      pace();
      start        <= 1'b1;
      req_kind     <= k;
      req_argument <= a;
      do @(posedge clock); while (busy);
      predicted = advance_bitmap(k, a);
      pending_answers.insert(pending_answers.size(), typed ? typed_answer : predicted);
   endtask

   // Register write only with the block idle: nothing owed and busy low.
   task automatic program_span(logic [LAST_W-1:0] v);
      start <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0 || busy);
      csr_write_enable  <= 1'b1;
      csr_last_position <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      span_last = v;
   endtask

   // One setting of last_position: restore first so the tree reflects the new
   // span, then mostly well-formed removes (of present positions) and finds
   // (of ranks in range), with some noise and an occasional restore.
   task automatic run_phase(logic [LAST_W-1:0] v, int unsigned n);
      int unsigned      roll;
      int unsigned      sub;
      logic [ARG_W-1:0] a;
      op_type           k;
      program_span(v);
      bursty     = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      issue_item(OP_RESTORE, ARG_W'($urandom_range(0, 2047)), 1'b0, NO_ANSWER);
      for (int i = 1; i < n; i++) begin
         roll = $urandom_range(0, 99);
         sub  = $urandom_range(0, 9);
         a    = ARG_W'($urandom_range(0, 2047));
         if (roll < 3) begin
            k = OP_RESTORE;
         end else if (roll < 45) begin
            k = OP_REMOVE;
            if (live_count != 0 && sub < 8)
               a = ARG_W'(nth_present($urandom_range(1, live_count)));
            else if (sub == 8)
               a = ARG_W'($urandom_range(0, int'(span_last) + 2));
         end else if (roll < 92) begin
            k = OP_FIND;
            if (live_count != 0 && sub < 7)
               a = ARG_W'($urandom_range(1, live_count));
            else if (sub == 7)
               a = '0;
            else if (sub == 8)
               a = ARG_W'(live_count + 1);
         end else begin
            k = OP_NONE;
         end
         issue_item(k, a, 1'b0, NO_ANSWER);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result checker: each strobe is matched with the oldest owed result.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      answer_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected result: found_position %0d remaining_count %0d",
                   rsp_found_position, rsp_remaining_count);
            mismatches++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_found_position !== want.found) begin
               $error("found_position: expected %0d, got %0d",
                      want.found, rsp_found_position);
               mismatches++;
            end
            if (rsp_rank_out_of_range !== want.out_of_range) begin
               $error("rank_out_of_range: expected %0d, got %0d",
                      want.out_of_range, rsp_rank_out_of_range);
               mismatches++;
            end
            if (rsp_remaining_count !== want.count) begin
               $error("remaining_count: expected %0d, got %0d",
                      want.count, rsp_remaining_count);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: cycles with neither an item taken nor a result delivered.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [LAST_W-1:0] span_plan [PHASE_COUNT];

      reset             = 1'b1;
      start             = 1'b0;
      req_kind          = OP_RESTORE;
      req_argument      = '0;
      csr_write_enable  = 1'b0;
      csr_last_position = LAST_RESET;

      // reset state: full span present
      span_last = LAST_RESET;
      void'(advance_bitmap(OP_RESTORE, '0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part; the first item waits out the sweep after reset
      bursty = 1'b0;
      foreach (DIR_PLAN[r]) begin
         if (DIR_PLAN[r].set_span)
            program_span(DIR_PLAN[r].span);
         issue_item(DIR_PLAN[r].kind, DIR_PLAN[r].argument, DIR_PLAN[r].typed,
                    DIR_PLAN[r].answer);
      end

      // small spans drain to empty often; the extremes are in the mix
      span_plan[0]  = 10'd1;
      span_plan[1]  = 10'd2;
      span_plan[2]  = 10'd1023;
      span_plan[3]  = LAST_W'($urandom_range(3, 15));
      span_plan[4]  = LAST_W'($urandom_range(16, 100));
      span_plan[5]  = LAST_W'($urandom_range(0, 1023));
      span_plan[6]  = 10'd0;
      span_plan[7]  = 10'd1023;
      span_plan[8]  = LAST_W'($urandom_range(2, 31));
      span_plan[9]  = 10'd511;
      span_plan[10] = LAST_W'($urandom_range(0, 1023));
      span_plan[11] = 10'd7;

      foreach (span_plan[ph])
         run_phase(span_plan[ph], PHASE_ITEMS);

      // drain, then watch a little longer for stray results
      start <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
